@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Clocked assertion that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ src/selu_pkg.sv @@
// Types, codes and default limits of the shared/exclusive lock unit.
package selu_pkg;

  localparam int unsigned DEF_ID_BITS       = 8;
  localparam int unsigned DEF_MAX_SHARERS   = 255;
  localparam int unsigned DEF_MAX_RECURSION = 255;
  localparam int unsigned DEF_MAX_WAITERS   = 255;

  localparam int unsigned REQ_ID_W = 8;
  localparam int unsigned HOLD_W   = 9;
  localparam int unsigned HOLD_MAX = 511;

  localparam logic [2:0] MODE_SHARED    = 3'd0;
  localparam logic [2:0] MODE_EXCLUSIVE = 3'd1;
  localparam logic [2:0] MODE_UPGRADE   = 3'd2;
  localparam logic [2:0] MODE_DOWNGRADE = 3'd3;
  localparam logic [2:0] MODE_RELEASE   = 3'd4;
  localparam logic [2:0] MODE_DRAIN     = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam logic [2:0] FLT_NONE          = 3'd0;
  localparam logic [2:0] FLT_UPG_UNSHARED  = 3'd1;
  localparam logic [2:0] FLT_DOWN_UNOWNED  = 3'd2;
  localparam logic [2:0] FLT_REL_NONOWNER  = 3'd3;
  localparam logic [2:0] FLT_REL_UNLOCKED  = 3'd4;
  localparam logic [2:0] FLT_BAD_OP        = 3'd5;

  localparam logic [1:0] LOCK_FREE   = 2'd0;
  localparam logic [1:0] LOCK_SHARED = 2'd1;
  localparam logic [1:0] LOCK_EXCL   = 2'd2;

  // Flag register bit positions.
  localparam int unsigned FB_HAVE    = 0;
  localparam int unsigned FB_WEXCL   = 1;
  localparam int unsigned FB_WUPG    = 2;
  localparam int unsigned FB_WDRAIN  = 3;
  localparam int unsigned FB_DRAINED = 4;
  localparam int unsigned FLAG_W     = 5;

  typedef struct packed {
    logic [2:0]          mode;
    logic [REQ_ID_W-1:0] requester;
    logic                nowait;
    logic                retry;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [2:0]          fault_kind;
    logic                wake_all;
    logic                boost_owner;
    logic [REQ_ID_W-1:0] boost_target;
    logic                unboost;
    logic [1:0]          lock_state;
    logic [HOLD_W-1:0]   hold_count;
    logic                drained;
  } rsp_t;

endpackage

@@ src/shared_exclusive_lock_unit.sv @@
// Top level of the shared/exclusive lock unit.
// A reader/writer lock for one lock object, with writer preference, recursive exclusive
// ownership, upgrade, downgrade, release and drain. A request passes through an input
// register and is decided against the lock state combinationally, its response landing in
// an output register; one request is taken every cycle while no stalled response blocks
// it, and its response is presented from the output register. The input register moves
// on whenever the output register is empty or its response is taken in the same cycle,
// so only a response held by a stall blocks the next request.
module shared_exclusive_lock_unit #(
  parameter int unsigned ID_BITS       = selu_pkg::DEF_ID_BITS,
  parameter int unsigned MAX_SHARERS   = selu_pkg::DEF_MAX_SHARERS,
  parameter int unsigned MAX_RECURSION = selu_pkg::DEF_MAX_RECURSION,
  parameter int unsigned MAX_WAITERS   = selu_pkg::DEF_MAX_WAITERS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  selu_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output selu_pkg::rsp_t out_rsp_o
);
  import selu_pkg::*;

  localparam int unsigned IdW  = (ID_BITS < REQ_ID_W) ? ID_BITS : REQ_ID_W;
  localparam int unsigned ShW  = $clog2(MAX_SHARERS + 1);
  localparam int unsigned RcW  = $clog2(MAX_RECURSION + 1);
  localparam int unsigned WtW  = $clog2(MAX_WAITERS + 1);
  localparam int unsigned SumW = ((ShW > RcW) ? ShW : RcW) + 1;

  logic              stage_vld_q;
  req_t              req_q;
  logic              out_vld_q;
  rsp_t              rsp_q;
  logic              advance;

  logic [FLAG_W-1:0] flags_q, flags_d;
  logic [ShW-1:0]    share_q, share_d;
  logic [RcW-1:0]    depth_q, depth_d;
  logic [WtW-1:0]    waiters_q, waiters_d;
  logic [IdW-1:0]    owner_q, owner_d;
  logic              ovalid_q, ovalid_d;

  logic [IdW-1:0]    id;
  logic              can_wait;
  logic              faulted;
  logic [SumW-1:0]   hold_sum;
  rsp_t              rsp_d;

  assign advance    = stage_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = stage_vld_q && !advance;
  assign id         = IdW'(req_q.requester);
  assign can_wait   = req_q.retry || (waiters_q < WtW'(MAX_WAITERS));

  always_comb begin
    flags_d   = flags_q;
    share_d   = share_q;
    depth_d   = depth_q;
    waiters_d = waiters_q;
    owner_d   = owner_q;
    ovalid_d  = ovalid_q;
    faulted   = 1'b0;
    rsp_d     = '0;

    unique case (req_q.mode)
      MODE_SHARED: begin
        if (flags_q[FB_HAVE] || flags_q[FB_WEXCL] || flags_q[FB_WDRAIN]) begin
          if (!req_q.nowait && can_wait) begin
            rsp_d.status      = ST_WAIT;
            rsp_d.boost_owner = ovalid_q;
            if (!req_q.retry) waiters_d = waiters_q + 1'b1;
          end else begin
            rsp_d.status = ST_BUSY;
            if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
          end
        end else begin
          if (share_q >= ShW'(MAX_SHARERS)) rsp_d.status = ST_BUSY;
          else share_d = share_q + 1'b1;
          if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
        end
      end
      MODE_EXCLUSIVE: begin
        if (ovalid_q && flags_q[FB_HAVE] && owner_q == id) begin
          if (depth_q >= RcW'(MAX_RECURSION)) rsp_d.status = ST_BUSY;
          else depth_d = depth_q + 1'b1;
          if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
        end else begin
          if (!req_q.retry) flags_d[FB_WEXCL] = 1'b1;
          if (share_q != '0 || flags_q[FB_HAVE]) begin
            if (!req_q.nowait && can_wait) begin
              rsp_d.status      = ST_WAIT;
              rsp_d.boost_owner = ovalid_q;
              if (!req_q.retry) waiters_d = waiters_q + 1'b1;
            end else begin
              flags_d[FB_WEXCL] = 1'b0;
              rsp_d.status      = ST_BUSY;
              if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
            end
          end else begin
            flags_d[FB_WEXCL] = 1'b0;
            flags_d[FB_WUPG]  = 1'b0;
            flags_d[FB_HAVE]  = 1'b1;
            owner_d           = id;
            ovalid_d          = 1'b1;
            depth_d           = RcW'(1);
            if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
          end
        end
      end
      MODE_UPGRADE: begin
        if (!req_q.retry && share_q == '0) begin
          faulted          = 1'b1;
          rsp_d.fault_kind = FLT_UPG_UNSHARED;
        end else if (!req_q.retry && flags_q[FB_WUPG]) begin
          rsp_d.status = ST_BUSY;
        end else begin
          if (!req_q.retry) begin
            share_d           = share_q - 1'b1;
            flags_d[FB_WEXCL] = 1'b1;
            flags_d[FB_WUPG]  = 1'b1;
          end
          if (share_d != '0 || flags_q[FB_HAVE]) begin
            if (!req_q.nowait && can_wait) begin
              rsp_d.status = ST_WAIT;
              if (!req_q.retry) waiters_d = waiters_q + 1'b1;
            end else begin
              if (share_d < ShW'(MAX_SHARERS)) share_d = share_d + 1'b1;
              flags_d[FB_WEXCL] = 1'b0;
              flags_d[FB_WUPG]  = 1'b0;
              rsp_d.status      = ST_BUSY;
              if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
            end
          end else begin
            flags_d[FB_WEXCL] = 1'b0;
            flags_d[FB_WUPG]  = 1'b0;
            flags_d[FB_HAVE]  = 1'b1;
            owner_d           = id;
            ovalid_d          = 1'b1;
            depth_d           = RcW'(1);
            if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
          end
        end
      end
      MODE_DOWNGRADE: begin
        if (!flags_q[FB_HAVE] || !ovalid_q || owner_q != id) begin
          faulted          = 1'b1;
          rsp_d.fault_kind = FLT_DOWN_UNOWNED;
        end else begin
          flags_d[FB_HAVE] = 1'b0;
          ovalid_d         = 1'b0;
          owner_d          = '0;
          depth_d          = '0;
          share_d          = ShW'(1);
          rsp_d.unboost    = 1'b1;
          rsp_d.wake_all   = (waiters_q != '0);
        end
      end
      MODE_RELEASE: begin
        if (flags_q[FB_HAVE]) begin
          if (!ovalid_q || owner_q != id) begin
            faulted          = 1'b1;
            rsp_d.fault_kind = FLT_REL_NONOWNER;
          end else begin
            if (depth_q != '0) depth_d = depth_q - 1'b1;
            if (depth_d == '0) begin
              flags_d[FB_HAVE] = 1'b0;
              ovalid_d         = 1'b0;
              owner_d          = '0;
              rsp_d.unboost    = 1'b1;
              rsp_d.wake_all   = (waiters_q != '0);
            end
          end
        end else if (share_q != '0) begin
          share_d = share_q - 1'b1;
          if (share_d == '0 && waiters_q != '0) rsp_d.wake_all = 1'b1;
        end else begin
          faulted          = 1'b1;
          rsp_d.fault_kind = FLT_REL_UNLOCKED;
        end
        if (!faulted && flags_d[FB_WDRAIN] && share_d == '0 && depth_d == '0) begin
          flags_d[FB_WDRAIN]  = 1'b0;
          flags_d[FB_DRAINED] = 1'b1;
          rsp_d.wake_all      = 1'b1;
        end
      end
      MODE_DRAIN: begin
        if (!req_q.retry) flags_d[FB_WDRAIN] = 1'b1;
        if (share_q != '0 || depth_q != '0) begin
          if (!req_q.nowait && can_wait) begin
            rsp_d.status = ST_WAIT;
            if (!req_q.retry) waiters_d = waiters_q + 1'b1;
          end else begin
            flags_d[FB_WDRAIN] = 1'b0;
            rsp_d.status       = ST_BUSY;
            if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
          end
        end else begin
          flags_d[FB_WDRAIN]  = 1'b0;
          flags_d[FB_DRAINED] = 1'b1;
          if (req_q.retry && waiters_q != '0) waiters_d = waiters_q - 1'b1;
        end
      end
      default: begin
        faulted          = 1'b1;
        rsp_d.fault_kind = FLT_BAD_OP;
      end
    endcase

    if (faulted) begin
      flags_d   = flags_q;
      share_d   = share_q;
      depth_d   = depth_q;
      waiters_d = waiters_q;
      owner_d   = owner_q;
      ovalid_d  = ovalid_q;
      rsp_d     = '0;
      rsp_d.status     = ST_FAULT;
      rsp_d.fault_kind = (req_q.mode == MODE_UPGRADE)   ? FLT_UPG_UNSHARED :
                         (req_q.mode == MODE_DOWNGRADE) ? FLT_DOWN_UNOWNED :
                         (req_q.mode == MODE_RELEASE)   ?
                           (flags_q[FB_HAVE] ? FLT_REL_NONOWNER : FLT_REL_UNLOCKED) :
                         FLT_BAD_OP;
    end

    rsp_d.boost_target = rsp_d.boost_owner ? REQ_ID_W'(owner_d) : '0;
    rsp_d.lock_state   = flags_d[FB_HAVE] ? LOCK_EXCL :
                         ((share_d != '0) ? LOCK_SHARED : LOCK_FREE);
    hold_sum           = SumW'(share_d) + SumW'(depth_d);
    rsp_d.hold_count   = (32'(hold_sum) > HOLD_MAX) ? HOLD_W'(HOLD_MAX) : HOLD_W'(hold_sum);
    rsp_d.drained      = flags_d[FB_DRAINED];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
      flags_q     <= '0;
      share_q     <= '0;
      depth_q     <= '0;
      waiters_q   <= '0;
      owner_q     <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        stage_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        flags_q   <= flags_d;
        share_q   <= share_d;
        depth_q   <= depth_d;
        waiters_q <= waiters_d;
        owner_q   <= owner_d;
        ovalid_q  <= ovalid_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ src/selu_checker.sv @@
// Port-level assertion checker for the shared/exclusive lock unit, with its bind.
`include "assert_macros.svh"

module selu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input selu_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input selu_pkg::rsp_t out_rsp_o
);
  import selu_pkg::*;

  logic req_held;
  logic rsp_held;
  logic rsp_fault;
  logic rsp_side;
  logic rsp_kind;
  logic rsp_free;
  logic rsp_empty;

  assign req_held  = in_valid_i && in_stall_o;
  assign rsp_held  = out_valid_o && out_stall_i;
  assign rsp_fault = (out_rsp_o.status == ST_FAULT);
  assign rsp_side  = out_rsp_o.wake_all || out_rsp_o.boost_owner || out_rsp_o.unboost;
  assign rsp_kind  = (out_rsp_o.fault_kind != FLT_NONE);
  assign rsp_free  = (out_rsp_o.lock_state == LOCK_FREE);
  assign rsp_empty = (out_rsp_o.hold_count == '0);

  // A stalled request must hold still.
  `ASSERT_CLK(a_req_hold, clk_i, rst_ni, req_held |=> in_valid_i && $stable(in_req_i))

  // A stalled response must hold still.
  `ASSERT_CLK(a_rsp_hold, clk_i, rst_ni, rsp_held |=> out_valid_o && $stable(out_rsp_o))

  // A fault carries no side indications.
  `ASSERT_NEVER(a_fault_quiet, clk_i, rst_ni, out_valid_o && rsp_fault && rsp_side)

  // Only a fault reports a fault kind, and a fault always reports one.
  `ASSERT_CLK(a_fault_kind, clk_i, rst_ni, out_valid_o |-> (rsp_fault == rsp_kind))

  // The lock is free exactly when nothing is held.
  `ASSERT_CLK(a_free_empty, clk_i, rst_ni, out_valid_o |-> (rsp_free == rsp_empty))

endmodule

bind shared_exclusive_lock_unit selu_checker u_selu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

@@ tb/shared_exclusive_lock_unit_tb.sv @@
// Self-checking testbench for the shared/exclusive lock unit, with its own model of the lock.
module shared_exclusive_lock_unit_tb;
  import selu_pkg::*;

  localparam int unsigned N_SHARERS   = DEF_MAX_SHARERS;
  localparam int unsigned N_RECURSION = DEF_MAX_RECURSION;
  localparam int unsigned N_WAITERS   = DEF_MAX_WAITERS;
  localparam int unsigned N_RANDOM    = 950;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  // Model of the lock state.
  logic [FLAG_W-1:0]   lk_bits     = '0;
  int unsigned         lk_shares   = 0;
  int unsigned         lk_depth    = 0;
  int unsigned         lk_waiters  = 0;
  logic [REQ_ID_W-1:0] lk_owner    = '0;
  bit                  lk_owner_ok = 1'b0;

  rsp_t        lock_answers [$];
  rsp_t        want_rsp;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  bit          gaps_on      = 1'b1;
  bit          stalls_on    = 1'b1;
  int          burst_left   = 0;
  int          holdoff_left = 0;
  int          run_left     = 0;
  bit          run_stall    = 1'b0;

  shared_exclusive_lock_unit #(
    .ID_BITS      (DEF_ID_BITS),
    .MAX_SHARERS  (N_SHARERS),
    .MAX_RECURSION(N_RECURSION),
    .MAX_WAITERS  (N_WAITERS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Returns whether a blocked request may wait, counting a first request as a new waiter.
  function automatic bit join_waiters(req_t r);
    if (r.nowait) return 1'b0;
    if (r.retry) return 1'b1;
    if (lk_waiters >= N_WAITERS) return 1'b0;
    lk_waiters++;
    return 1'b1;
  endfunction

  function automatic void leave_waiters(bit is_retry);
    if (is_retry && lk_waiters > 0) lk_waiters--;
  endfunction

  function automatic void grant_exclusive(logic [REQ_ID_W-1:0] id);
    lk_bits[FB_WEXCL] = 1'b0;
    lk_bits[FB_WUPG]  = 1'b0;
    lk_bits[FB_HAVE]  = 1'b1;
    lk_owner          = id;
    lk_owner_ok       = 1'b1;
    lk_depth          = 1;
  endfunction

  function automatic rsp_t decide_lock(req_t r);
    rsp_t        o;
    int unsigned hold;
    o = '0;
    case (r.mode)
      MODE_SHARED: begin
        if (lk_bits[FB_HAVE] || lk_bits[FB_WEXCL] || lk_bits[FB_WDRAIN]) begin
          if (join_waiters(r)) begin
            o.status      = ST_WAIT;
            o.boost_owner = lk_owner_ok;
          end else begin
            o.status = ST_BUSY;
            leave_waiters(r.retry);
          end
        end else if (lk_shares >= N_SHARERS) begin
          o.status = ST_BUSY;
          leave_waiters(r.retry);
        end else begin
          lk_shares++;
          leave_waiters(r.retry);
        end
      end
      MODE_EXCLUSIVE: begin
        if (lk_owner_ok && lk_bits[FB_HAVE] && lk_owner == r.requester) begin
          if (lk_depth >= N_RECURSION) o.status = ST_BUSY;
          else lk_depth++;
          leave_waiters(r.retry);
        end else begin
          if (!r.retry) lk_bits[FB_WEXCL] = 1'b1;
          if (lk_shares > 0 || lk_bits[FB_HAVE]) begin
            if (join_waiters(r)) begin
              o.status      = ST_WAIT;
              o.boost_owner = lk_owner_ok;
            end else begin
              lk_bits[FB_WEXCL] = 1'b0;
              o.status          = ST_BUSY;
              leave_waiters(r.retry);
            end
          end else begin
            grant_exclusive(r.requester);
            leave_waiters(r.retry);
          end
        end
      end
      MODE_UPGRADE: begin
        if (!r.retry && lk_shares == 0) begin
          o.status     = ST_FAULT;
          o.fault_kind = FLT_UPG_UNSHARED;
        end else if (!r.retry && lk_bits[FB_WUPG]) begin
          o.status = ST_BUSY;
        end else begin
          if (!r.retry) begin
            lk_shares--;
            lk_bits[FB_WEXCL] = 1'b1;
            lk_bits[FB_WUPG]  = 1'b1;
          end
          if (lk_shares > 0 || lk_bits[FB_HAVE]) begin
            if (join_waiters(r)) begin
              o.status = ST_WAIT;
            end else begin
              if (lk_shares < N_SHARERS) lk_shares++;
              lk_bits[FB_WEXCL] = 1'b0;
              lk_bits[FB_WUPG]  = 1'b0;
              o.status          = ST_BUSY;
              leave_waiters(r.retry);
            end
          end else begin
            grant_exclusive(r.requester);
            leave_waiters(r.retry);
          end
        end
      end
      MODE_DOWNGRADE: begin
        if (!lk_bits[FB_HAVE] || !lk_owner_ok || lk_owner != r.requester) begin
          o.status     = ST_FAULT;
          o.fault_kind = FLT_DOWN_UNOWNED;
        end else begin
          lk_bits[FB_HAVE] = 1'b0;
          lk_owner_ok      = 1'b0;
          lk_owner         = '0;
          lk_depth         = 0;
          lk_shares        = 1;
          o.unboost        = 1'b1;
          o.wake_all       = lk_waiters > 0;
        end
      end
      MODE_RELEASE: begin
        if (lk_bits[FB_HAVE] && (!lk_owner_ok || lk_owner != r.requester)) begin
          o.status     = ST_FAULT;
          o.fault_kind = FLT_REL_NONOWNER;
        end else if (!lk_bits[FB_HAVE] && lk_shares == 0) begin
          o.status     = ST_FAULT;
          o.fault_kind = FLT_REL_UNLOCKED;
        end else begin
          if (lk_bits[FB_HAVE]) begin
            if (lk_depth > 0) lk_depth--;
            if (lk_depth == 0) begin
              lk_bits[FB_HAVE] = 1'b0;
              lk_owner_ok      = 1'b0;
              lk_owner         = '0;
              o.unboost        = 1'b1;
              o.wake_all       = lk_waiters > 0;
            end
          end else begin
            lk_shares--;
            if (lk_shares == 0 && lk_waiters > 0) o.wake_all = 1'b1;
          end
          if (lk_bits[FB_WDRAIN] && lk_shares == 0 && lk_depth == 0) begin
            lk_bits[FB_WDRAIN]  = 1'b0;
            lk_bits[FB_DRAINED] = 1'b1;
            o.wake_all          = 1'b1;
          end
        end
      end
      MODE_DRAIN: begin
        if (!r.retry) lk_bits[FB_WDRAIN] = 1'b1;
        if (lk_shares > 0 || lk_depth > 0) begin
          if (join_waiters(r)) begin
            o.status = ST_WAIT;
          end else begin
            lk_bits[FB_WDRAIN] = 1'b0;
            o.status           = ST_BUSY;
            leave_waiters(r.retry);
          end
        end else begin
          lk_bits[FB_WDRAIN]  = 1'b0;
          lk_bits[FB_DRAINED] = 1'b1;
          leave_waiters(r.retry);
        end
      end
      default: begin
        o.status     = ST_FAULT;
        o.fault_kind = FLT_BAD_OP;
      end
    endcase
    if (o.boost_owner) o.boost_target = lk_owner;
    if (lk_bits[FB_HAVE]) o.lock_state = LOCK_EXCL;
    else if (lk_shares > 0) o.lock_state = LOCK_SHARED;
    else o.lock_state = LOCK_FREE;
    hold         = lk_shares + lk_depth;
    o.hold_count = HOLD_W'((hold > HOLD_MAX) ? HOLD_MAX : hold);
    o.drained    = lk_bits[FB_DRAINED];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("%0t: mismatch in %s, got %0d, want %0d", $time, what, got, want);
  endtask

  // Offers one request from a falling edge and returns at the falling edge after it is taken.
  task automatic send_req(input req_t r, output rsp_t pred);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred = decide_lock(r);
    lock_answers.push_back(pred);
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [2:0] m, input logic [REQ_ID_W-1:0] id, input bit nw,
                         input bit rt, output rsp_t pred);
    req_t r;
    r.mode      = m;
    r.requester = id;
    r.nowait    = nw;
    r.retry     = rt;
    send_req(r, pred);
  endtask

  task automatic wait_for_responses();
    in_valid_i <= 1'b0;
    while (lock_answers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Brings the lock back to free with no pending writer, upgrader or drain.
  task automatic unlock_all();
    rsp_t p;
    while (lk_bits[FB_HAVE] || lk_shares != 0 || lk_bits[FB_WEXCL] || lk_bits[FB_WUPG] ||
           lk_bits[FB_WDRAIN]) begin
      if (lk_bits[FB_HAVE]) send_op(MODE_RELEASE, lk_owner, 1'b0, 1'b0, p);
      else if (lk_shares != 0) send_op(MODE_RELEASE, 8'($urandom_range(0, 255)), 1'b0, 1'b0, p);
      else if (lk_bits[FB_WEXCL] || lk_bits[FB_WUPG])
        send_op(MODE_EXCLUSIVE, 8'($urandom_range(0, 255)), 1'b1, 1'b1, p);
      else send_op(MODE_DRAIN, 8'($urandom_range(0, 255)), 1'b1, 1'b1, p);
    end
  endtask

  task automatic test_directed_cases();
    rsp_t p;
    send_op(MODE_RELEASE, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_DOWNGRADE, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_UPGRADE, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_DRAIN + 3'd1, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_DRAIN + 3'd2, 8'hFF, 1'b1, 1'b1, p);
    send_op(MODE_DRAIN, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_SHARED, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_SHARED, 8'hFF, 1'b0, 1'b0, p);
    send_op(MODE_UPGRADE, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_UPGRADE, 8'hFF, 1'b0, 1'b0, p);
    send_op(MODE_SHARED, 8'h5A, 1'b1, 1'b0, p);
    send_op(MODE_RELEASE, 8'hFF, 1'b0, 1'b0, p);
    send_op(MODE_UPGRADE, 8'h00, 1'b0, 1'b1, p);
    send_op(MODE_EXCLUSIVE, 8'h00, 1'b0, 1'b0, p);
    send_op(MODE_EXCLUSIVE, 8'hA5, 1'b1, 1'b0, p);
    send_op(MODE_EXCLUSIVE, 8'hA5, 1'b0, 1'b0, p);
    send_op(MODE_SHARED, 8'h3C, 1'b0, 1'b0, p);
    send_op(MODE_RELEASE, 8'hA5, 1'b0, 1'b0, p);
    send_op(MODE_RELEASE, 8'h00, 1'b0, 1'b1, p);
    send_op(MODE_DOWNGRADE, 8'h00, 1'b1, 1'b1, p);
    send_op(MODE_EXCLUSIVE, 8'hA5, 1'b0, 1'b1, p);
    send_op(MODE_DRAIN, 8'h11, 1'b0, 1'b0, p);
    send_op(MODE_RELEASE, 8'h22, 1'b0, 1'b0, p);
    send_op(MODE_DRAIN, 8'h11, 1'b0, 1'b1, p);
    send_op(MODE_EXCLUSIVE, 8'hA5, 1'b0, 1'b1, p);
    send_op(MODE_SHARED, 8'h3C, 1'b1, 1'b1, p);
  endtask

  task automatic test_share_and_waiter_limits();
    rsp_t                p;
    logic [REQ_ID_W-1:0] holder;
    int                  guard;
    unlock_all();
    holder = 8'($urandom_range(0, 255));
    send_op(MODE_EXCLUSIVE, holder, 1'b0, 1'b0, p);
    guard = 0;
    do begin
      send_op(MODE_SHARED, 8'($urandom_range(0, 255)), 1'b0, 1'b0, p);
      guard++;
    end while (p.status == ST_WAIT && guard < 2 * N_WAITERS);
    send_op(MODE_RELEASE, holder, 1'b0, 1'b0, p);
    // Waiters retry one by one; the share count reaches its limit as they drain.
    while (lk_waiters > 0)
      send_op(MODE_SHARED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, p);
    send_op(MODE_SHARED, 8'($urandom_range(0, 255)), 1'b0, 1'b0, p);
    unlock_all();
  endtask

  task automatic test_recursion_limit();
    rsp_t                p;
    logic [REQ_ID_W-1:0] holder;
    int                  guard;
    unlock_all();
    holder = 8'($urandom_range(0, 255));
    guard  = 0;
    do begin
      send_op(MODE_EXCLUSIVE, holder, 1'($urandom_range(0, 1)), 1'b0, p);
      guard++;
    end while (p.status == ST_DONE && guard < 2 * N_RECURSION);
    send_op(MODE_RELEASE, holder + 8'd1, 1'b0, 1'b0, p);
    send_op(MODE_EXCLUSIVE, holder, 1'b0, 1'b1, p);
    unlock_all();
  endtask

  task automatic test_output_holdoff();
    rsp_t p;
    int   k;
    wait_for_responses();
    gaps_on      = 1'b0;
    holdoff_left = 120;
    for (k = 0; k < 24; k++)
      send_op((k % 2) ? MODE_RELEASE : MODE_SHARED, 8'($urandom_range(0, 255)), 1'b0, 1'b0, p);
    wait_for_responses();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    req_t                r;
    rsp_t                p;
    req_t                parked_reqs [$];
    logic [REQ_ID_W-1:0] agents [8];
    int                  k;
    int                  pick;
    int                  w;
    foreach (agents[i]) agents[i] = 8'($urandom_range(0, 255));
    agents[0] = 8'h00;
    agents[1] = 8'hFF;
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 120 == 0) begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25 && parked_reqs.size() > 0) begin
        w       = $urandom_range(0, parked_reqs.size() - 1);
        r       = parked_reqs[w];
        r.retry = 1'b1;
        r.nowait = $urandom_range(0, 4) == 0;
        send_req(r, p);
        if (p.status != ST_WAIT) parked_reqs.delete(w);
      end else if (pick < 32) begin
        r.mode      = 3'($urandom_range(0, 7));
        r.requester = 8'($urandom_range(0, 255));
        r.nowait    = 1'($urandom_range(0, 1));
        r.retry     = 1'($urandom_range(0, 1));
        send_req(r, p);
      end else begin
        w = $urandom_range(0, 99);
        if (w < 26) r.mode = MODE_SHARED;
        else if (w < 46) r.mode = MODE_EXCLUSIVE;
        else if (w < 72) r.mode = MODE_RELEASE;
        else if (w < 82) r.mode = MODE_UPGRADE;
        else if (w < 92) r.mode = MODE_DOWNGRADE;
        else if (w < 97) r.mode = MODE_DRAIN;
        else r.mode = MODE_DRAIN + 3'($urandom_range(1, 2));
        if ((r.mode == MODE_RELEASE || r.mode == MODE_DOWNGRADE || r.mode == MODE_EXCLUSIVE) &&
            lk_owner_ok && $urandom_range(0, 9) < 6)
          r.requester = lk_owner;
        else if ($urandom_range(0, 9) == 0)
          r.requester = 8'($urandom_range(0, 255));
        else
          r.requester = agents[$urandom_range(0, 7)];
        r.nowait = $urandom_range(0, 9) < 3;
        r.retry  = 1'b0;
        send_req(r, p);
        if (p.status == ST_WAIT && parked_reqs.size() < 64) parked_reqs.push_back(r);
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (!stalls_on) begin
      out_stall_i <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_stall = !run_stall;
        run_left  = run_stall ? $urandom_range(1, 4) : $urandom_range(1, 10);
      end
      run_left--;
      out_stall_i <= run_stall;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lock_answers.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want_rsp = lock_answers.pop_front();
        if (out_rsp_o.status !== want_rsp.status)
          report_mismatch("status", int'(out_rsp_o.status), int'(want_rsp.status));
        if (out_rsp_o.fault_kind !== want_rsp.fault_kind)
          report_mismatch("fault_kind", int'(out_rsp_o.fault_kind), int'(want_rsp.fault_kind));
        if (out_rsp_o.wake_all !== want_rsp.wake_all)
          report_mismatch("wake_all", int'(out_rsp_o.wake_all), int'(want_rsp.wake_all));
        if (out_rsp_o.boost_owner !== want_rsp.boost_owner)
          report_mismatch("boost_owner", int'(out_rsp_o.boost_owner),
                          int'(want_rsp.boost_owner));
        if (out_rsp_o.boost_target !== want_rsp.boost_target)
          report_mismatch("boost_target", int'(out_rsp_o.boost_target),
                          int'(want_rsp.boost_target));
        if (out_rsp_o.unboost !== want_rsp.unboost)
          report_mismatch("unboost", int'(out_rsp_o.unboost), int'(want_rsp.unboost));
        if (out_rsp_o.lock_state !== want_rsp.lock_state)
          report_mismatch("lock_state", int'(out_rsp_o.lock_state), int'(want_rsp.lock_state));
        if (out_rsp_o.hold_count !== want_rsp.hold_count)
          report_mismatch("hold_count", int'(out_rsp_o.hold_count), int'(want_rsp.hold_count));
        if (out_rsp_o.drained !== want_rsp.drained)
          report_mismatch("drained", int'(out_rsp_o.drained), int'(want_rsp.drained));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_share_and_waiter_limits();
    test_recursion_limit();
    test_output_holdoff();
    test_random_traffic();
    wait_for_responses();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
